/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/fosrq_pkg.sv */
// ----------------------------------------------------------------------------
// fosrq_pkg
// Shared types and codes for the FIFO / sorted ready queue.
// ----------------------------------------------------------------------------
package fosrq_pkg;

  // operation codes carried on the mode input
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;     // insert the new entry this cycle
    logic deq;     // pop the head this cycle
    logic sorted;  // insert by ascending key rather than at the tail
  } cell_ctrl_t;

endpackage

/* hdl/fosrq_cell.sv */
// ----------------------------------------------------------------------------
// fosrq_cell
// One slot of the queue. Holds an entry and, on each command, keeps it, takes
// the new entry, or takes the entry of a neighbour.
// ----------------------------------------------------------------------------
module fosrq_cell #(
  parameter int ID_BITS  = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                 clk,
  input  fosrq_pkg::cell_ctrl_t ctrl,
  input  logic                 occupied,
  input  logic                 found_in,
  output logic                 found_out,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [KEY_BITS-1:0]  new_key,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [KEY_BITS-1:0]  left_key,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic [KEY_BITS-1:0]  right_key,
  output logic [ID_BITS-1:0]   id,
  output logic [KEY_BITS-1:0]  key
);
  import fosrq_pkg::*;

  logic match;

  // first empty slot, or in sorted order the first stored key >= new key
  always_comb begin
    match     = !occupied || (ctrl.sorted && (key >= new_key));
    found_out = found_in || match;
  end

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (found_in) begin
        id  <= left_id;
        key <= left_key;
      end else if (match) begin
        id  <= new_id;
        key <= new_key;
      end
    end else if (ctrl.deq) begin
      id  <= right_id;
      key <= right_key;
    end
  end

endmodule

/* hdl/fifo_or_sorted_ready_queue.sv */
// ----------------------------------------------------------------------------
// fifo_or_sorted_ready_queue
// Bounded ready queue of (task id, cpu time) entries, FIFO or key ordered.
// ----------------------------------------------------------------------------
// Takes one enqueue or dequeue transaction per clock cycle and returns one
// result per item from an output register in the cycle after acceptance.
// Input is held off only in reset or while a result waits unread. The entries
// live in a row of CAPACITY cells; an insert finds its slot through a
// one-bit priority chain that runs through every cell, and that chain plus
// one KEY_BITS compare per cell set the clock period. Set order_by_cpu_time
// only while the queue is idle; entries already stored keep their order.
// ----------------------------------------------------------------------------
module fifo_or_sorted_ready_queue #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          order_by_cpu_time,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [ID_BITS-1:0]            task_id,
  input  logic [KEY_BITS-1:0]           used_time,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          out_valid,
  output logic [ID_BITS-1:0]            out_task_id,
  output logic [KEY_BITS-1:0]           out_cpu_time,
  output logic                          was_empty,
  output logic                          overflow,
  output logic                          head_valid,
  output logic [ID_BITS-1:0]            head_task_id,
  output logic                          queue_empty,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);
  import fosrq_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  logic          sorted_order;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  cell_ctrl_t    ctrl;

  logic [ID_BITS-1:0]  cell_id  [CAPACITY];
  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic                found    [CAPACITY+1];

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (!result_valid || result_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    ctrl.enq    = accept && (mode == MODE_ENQUEUE) && !full;
    ctrl.deq    = accept && (mode == MODE_DEQUEUE) && !empty;
    ctrl.sorted = sorted_order;
    count_next  = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_BITS-1:0]  l_id;
    logic [KEY_BITS-1:0] l_key;
    logic [ID_BITS-1:0]  r_id;
    logic [KEY_BITS-1:0] r_key;

    // head has no left neighbour: found_in is low there, so left is unused
    if (g == 0) begin : g_head
      assign l_id  = task_id;
      assign l_key = used_time;
    end else begin : g_mid
      assign l_id  = cell_id[g-1];
      assign l_key = cell_key[g-1];
    end

    // tail refills from itself; it falls out of the occupied range anyway
    if (g == CAPACITY - 1) begin : g_tail
      assign r_id  = cell_id[g];
      assign r_key = cell_key[g];
    end else begin : g_body
      assign r_id  = cell_id[g+1];
      assign r_key = cell_key[g+1];
    end

    fosrq_cell #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count > CW'(g)),
      .found_in  (found[g]),
      .found_out (found[g+1]),
      .new_id    (task_id),
      .new_key   (used_time),
      .left_id   (l_id),
      .left_key  (l_key),
      .right_id  (r_id),
      .right_key (r_key),
      .id        (cell_id[g]),
      .key       (cell_key[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_order <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sorted_order <= order_by_cpu_time;
      end
      count <= count_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid    <= ctrl.deq;
      out_task_id  <= ctrl.deq ? cell_id[0] : '0;
      out_cpu_time <= ctrl.deq ? cell_key[0] : '0;
      was_empty    <= (mode == MODE_DEQUEUE) && empty;
      overflow     <= (mode == MODE_ENQUEUE) && full;
    end
  end

  // state only moves when a result is loaded, so the peek view is live state
  assign head_valid   = !empty;
  assign head_task_id = empty ? '0 : cell_id[0];
  assign queue_empty  = empty;
  assign entry_count  = count;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_slot_found, clk, rst, !ctrl.enq || found[CAPACITY], "insert found no slot")
  `ASSERT_NEXT(a_enq_count, clk, rst, ctrl.enq, count == $past(count) + CW'(1), "enqueue count")
  `ASSERT_NEXT(a_deq_count, clk, rst, ctrl.deq, count == $past(count) - CW'(1), "dequeue count")
  `ASSERT_ALWAYS(a_flags, clk, rst, !result_valid || !(out_valid && (was_empty || overflow)),
                 "conflicting result flags")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO / sorted ready queue.
// ----------------------------------------------------------------------------
// A queue of pending operations, filled at time zero, feeds a clocked driver:
// a short directed run, then phases of random enqueue/dequeue traffic with the
// order bit rewritten between phases. Accepted requests are run through a
// shadow copy of the queue and every result transaction is checked field by
// field against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import fosrq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int LONG_HOLD   = 200;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {
    ITEM_REQ,    // request transaction
    ITEM_CFG,    // order bit write, once the queue has gone quiet
    ITEM_DRAIN,  // sender waits for every outstanding result
    ITEM_HOLD    // ask the receiver for a long hold-off
  } pending_kind_t;

  typedef struct {
    pending_kind_t kind;
    logic          op;
    logic [7:0]    id;
    logic [31:0]   key;
    logic          order_bit;
  } pending_op_t;

  typedef struct packed {
    logic        popped;
    logic [7:0]  pop_id;
    logic [31:0] pop_key;
    logic        found_empty;
    logic        dropped;
    logic        head_v;
    logic [7:0]  head_id;
    logic        now_empty;
    logic [4:0]  count;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        order_by_cpu_time = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_ENQUEUE;
  logic [7:0]  task_id = '0;
  logic [31:0] used_time = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        out_valid;
  logic [7:0]  out_task_id;
  logic [31:0] out_cpu_time;
  logic        was_empty;
  logic        overflow;
  logic        head_valid;
  logic [7:0]  head_task_id;
  logic        queue_empty;
  logic [4:0]  entry_count;

  fifo_or_sorted_ready_queue #(
    .CAPACITY(DEPTH),
    .ID_BITS (8),
    .KEY_BITS(32)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .order_by_cpu_time(order_by_cpu_time),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .task_id          (task_id),
    .used_time        (used_time),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_valid        (out_valid),
    .out_task_id      (out_task_id),
    .out_cpu_time     (out_cpu_time),
    .was_empty        (was_empty),
    .overflow         (overflow),
    .head_valid       (head_valid),
    .head_task_id     (head_task_id),
    .queue_empty      (queue_empty),
    .entry_count      (entry_count)
  );

  always #2 clk = ~clk;

  pending_op_t   pending_ops[$];
  queue_result_t expected_results[$];

  // shadow copy of the queue contents and the order bit
  logic [7:0]  shadow_ids[DEPTH];
  logic [31:0] shadow_keys[DEPTH];
  int          shadow_count = 0;
  logic        shadow_sorted = 1'b0;

  int   errors = 0;
  int   cycle_count = 0;
  logic req_taken = 1'b0;
  logic cfg_taken = 1'b0;
  bit   stim_done = 1'b0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   tx_gap = 0;
  int   tx_style = 0;
  int   tx_style_left = 0;
  int   rx_hold = 0;
  int   rx_style = 0;
  int   rx_style_left = 0;

  // one enqueue or dequeue applied to the shadow queue
  function automatic queue_result_t shadow_queue_op(logic op, logic [7:0] id,
                                                    logic [31:0] key);
    queue_result_t r;
    int            pos;
    r = '0;
    if (op == MODE_DEQUEUE) begin
      if (shadow_count == 0) begin
        r.found_empty = 1'b1;
      end else begin
        r.popped  = 1'b1;
        r.pop_id  = shadow_ids[0];
        r.pop_key = shadow_keys[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_ids[i-1]  = shadow_ids[i];
          shadow_keys[i-1] = shadow_keys[i];
        end
        shadow_count--;
      end
    end else if (shadow_count >= DEPTH) begin
      r.dropped = 1'b1;
    end else begin
      pos = shadow_count;
      if (shadow_sorted) begin
        // equal keys: the newcomer goes ahead
        pos = 0;
        while (pos < shadow_count && key > shadow_keys[pos]) pos++;
      end
      for (int i = shadow_count; i > pos; i--) begin
        shadow_ids[i]  = shadow_ids[i-1];
        shadow_keys[i] = shadow_keys[i-1];
      end
      shadow_ids[pos]  = id;
      shadow_keys[pos] = key;
      shadow_count++;
    end
    r.head_v    = (shadow_count != 0);
    r.head_id   = (shadow_count != 0) ? shadow_ids[0] : 8'h00;
    r.now_empty = (shadow_count == 0);
    r.count     = shadow_count[4:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e,
                             input logic [31:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
      errors++;
    end
  endtask

  function automatic int pick_tx_gap();
    int r;
    r = $urandom_range(0, 99);
    case (tx_style)
      0: return 0;
      1: return (r < 70) ? 0 : $urandom_range(1, 3);
      default: begin
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin : drive
    pending_op_t nxt;
    logic        n_valid;
    logic        n_cfg;
    n_valid = in_valid;
    n_cfg   = cfg_valid;
    if (!rst) begin
      if (in_valid && req_taken) begin
        n_valid = 1'b0;
        if (tx_style_left == 0) begin
          tx_style      = $urandom_range(0, 2);
          tx_style_left = $urandom_range(40, 200);
        end else begin
          tx_style_left--;
        end
        tx_gap = pick_tx_gap();
      end
      if (cfg_valid && cfg_taken) n_cfg = 1'b0;
      if (!n_valid && !n_cfg) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_ops.size() == 0) begin
          stim_done = 1'b1;
        end else begin
          nxt = pending_ops[0];
          case (nxt.kind)
            ITEM_REQ: begin
              n_valid = 1'b1;
              mode      <= nxt.op;
              task_id   <= nxt.id;
              used_time <= nxt.key;
              void'(pending_ops.pop_front());
            end
            ITEM_CFG: begin
              if (expected_results.size() == 0) begin
                n_cfg = 1'b1;
                order_by_cpu_time <= nxt.order_bit;
                void'(pending_ops.pop_front());
              end
            end
            ITEM_DRAIN: begin
              if (expected_results.size() == 0) void'(pending_ops.pop_front());
            end
            default: begin
              hold_asked++;
              void'(pending_ops.pop_front());
            end
          endcase
        end
      end
    end
    in_valid  <= n_valid;
    cfg_valid <= n_cfg;
  end

  // receiver: random stalls, quiet stretches and the odd long hold-off
  always @(negedge clk) begin : receive
    logic n_ready;
    int   r;
    n_ready = 1'b0;
    if (!rst) begin
      if (hold_served != hold_asked) begin
        hold_served++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
      end else begin
        if (rx_style_left == 0) begin
          rx_style      = $urandom_range(0, 2);
          rx_style_left = $urandom_range(50, 300);
        end else begin
          rx_style_left--;
        end
        r = $urandom_range(0, 99);
        case (rx_style)
          0: n_ready = 1'b1;
          1: n_ready = (r < 75);
          default: begin
            if (r < 55) n_ready = 1'b1;
            else if (r < 93) rx_hold = $urandom_range(1, 3);
            else rx_hold = $urandom_range(15, 40);
          end
        endcase
      end
    end
    result_ready <= n_ready;
  end

  // monitor: samples on the rising edge
  always @(posedge clk) begin : monitor
    queue_result_t exp_r;
    req_taken <= !rst && in_valid && in_ready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("out_valid",    32'(exp_r.popped),      32'(out_valid));
          check_field("out_task_id",  32'(exp_r.pop_id),      32'(out_task_id));
          check_field("out_cpu_time", exp_r.pop_key,          out_cpu_time);
          check_field("was_empty",    32'(exp_r.found_empty), 32'(was_empty));
          check_field("overflow",     32'(exp_r.dropped),     32'(overflow));
          check_field("head_valid",   32'(exp_r.head_v),      32'(head_valid));
          check_field("head_task_id", 32'(exp_r.head_id),     32'(head_task_id));
          check_field("queue_empty",  32'(exp_r.now_empty),   32'(queue_empty));
          check_field("entry_count",  32'(exp_r.count),       32'(entry_count));
        end
      end
      if (cfg_valid && cfg_ready) shadow_sorted = order_by_cpu_time;
      if (in_valid && in_ready)
        expected_results.push_back(shadow_queue_op(mode, task_id, used_time));
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_marker(pending_kind_t k, logic order_bit);
    pending_op_t p;
    p = '{kind: k, op: MODE_ENQUEUE, id: 8'h00, key: 32'h0, order_bit: order_bit};
    pending_ops.push_back(p);
  endfunction

  function automatic void push_req(logic op, logic [7:0] id, logic [31:0] key);
    pending_op_t p;
    p = '{kind: ITEM_REQ, op: op, id: id, key: key, order_bit: 1'b0};
    pending_ops.push_back(p);
  endfunction

  // random request; small keys are favoured so that ties turn up often
  function automatic void push_random_req(int enq_pct);
    logic [31:0] key;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 4) key = $urandom_range(0, 7);
    else if (r == 4) key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    else key = $urandom;
    push_req(($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE,
             8'($urandom_range(0, 255)), key);
  endfunction

  initial begin
    int enq_pct;
    // directed: FIFO basics, then a sorted fill with ties and extremes
    push_marker(ITEM_CFG, 1'b0);
    push_req(MODE_DEQUEUE, 8'h00, 32'h0);
    push_req(MODE_ENQUEUE, 8'h00, 32'h0);
    push_req(MODE_ENQUEUE, 8'hFF, 32'hFFFF_FFFF);
    push_req(MODE_DEQUEUE, 8'h00, 32'h0);
    push_req(MODE_DEQUEUE, 8'h00, 32'h0);
    push_marker(ITEM_CFG, 1'b1);
    for (int i = 0; i < DEPTH; i++)
      push_req(MODE_ENQUEUE, 8'hA0 + i[7:0],
               (i % 4 == 0) ? 32'd5 : (i % 4 == 1) ? 32'd0 :
               (i % 4 == 2) ? 32'hFFFF_FFFF : 32'd5);
    push_req(MODE_ENQUEUE, 8'h55, 32'd3);
    push_req(MODE_DEQUEUE, 8'h00, 32'h0);
    push_req(MODE_DEQUEUE, 8'h00, 32'h0);

    // random phases; the order bit changes with entries still stored
    for (int ph = 0; ph < 10; ph++) begin
      push_marker(ITEM_CFG, (ph < 2) ? ph[0] : logic'($urandom_range(0, 1)));
      if (ph == 2 || ph == 6) push_marker(ITEM_HOLD, 1'b0);
      case (ph % 5)
        0: enq_pct = 55;
        1: enq_pct = 85;
        2: enq_pct = 50;
        3: enq_pct = 20;
        default: enq_pct = 65;
      endcase
      for (int n = 0; n < 115; n++) begin
        if (ph == 4 && n == 60) push_marker(ITEM_DRAIN, 1'b0);
        push_random_req(enq_pct);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
